### hdl/rvd_pkg.sv
// Shared types and constants for the RV32I subset instruction decoder.
// Holds the transaction structs, opcode and funct constants and mnemonic codes.
// No dependencies; used by rvd_decode and rv32i_subset_instruction_decoder.
package rvd_pkg;

	// Mnemonic codes carried on the result transaction.
	typedef enum logic [4:0] {
		MN_ADD     = 5'd0,
		MN_SUB     = 5'd1,
		MN_SLL     = 5'd2,
		MN_SLT     = 5'd3,
		MN_SLTU    = 5'd4,
		MN_XOR     = 5'd5,
		MN_SRL     = 5'd6,
		MN_SRA     = 5'd7,
		MN_OR      = 5'd8,
		MN_AND     = 5'd9,
		MN_ADDI    = 5'd10,
		MN_LB      = 5'd11,
		MN_LH      = 5'd12,
		MN_LW      = 5'd13,
		MN_LBU     = 5'd14,
		MN_LHU     = 5'd15,
		MN_SB      = 5'd16,
		MN_SH      = 5'd17,
		MN_SW      = 5'd18,
		MN_AUIPC   = 5'd19,
		MN_LUI     = 5'd20,
		MN_JAL     = 5'd21,
		MN_BEQ     = 5'd22,
		MN_BNE     = 5'd23,
		MN_BLT     = 5'd24,
		MN_BGE     = 5'd25,
		MN_BLTU    = 5'd26,
		MN_BGEU    = 5'd27,
		MN_UNKNOWN = 5'd28
	} mnem_t;

	// Major opcodes, instruction bits 6 to 0.
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_BRANCH = 7'h63;

	// The funct7 bit that selects sub and sra.
	localparam int unsigned FN7_ALT_BIT = 5;

	// Register-register funct3 codes.
	localparam logic [2:0] F3_ADD_SUB = 3'd0;
	localparam logic [2:0] F3_SLL     = 3'd1;
	localparam logic [2:0] F3_SLT     = 3'd2;
	localparam logic [2:0] F3_SLTU    = 3'd3;
	localparam logic [2:0] F3_XOR     = 3'd4;
	localparam logic [2:0] F3_SRL_SRA = 3'd5;
	localparam logic [2:0] F3_OR      = 3'd6;
	localparam logic [2:0] F3_AND     = 3'd7;
	localparam logic [2:0] F3_ADDI    = 3'd0;

	// Load, store and branch funct3 codes.
	localparam logic [2:0] F3_LB   = 3'd0;
	localparam logic [2:0] F3_LH   = 3'd1;
	localparam logic [2:0] F3_LW   = 3'd2;
	localparam logic [2:0] F3_LBU  = 3'd4;
	localparam logic [2:0] F3_LHU  = 3'd5;
	localparam logic [2:0] F3_SB   = 3'd0;
	localparam logic [2:0] F3_SH   = 3'd1;
	localparam logic [2:0] F3_SW   = 3'd2;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// Mnemonic by funct3 for the load, store and branch groups.
	localparam mnem_t LOAD_CODE [8] = '{
		MN_LB, MN_LH, MN_LW, MN_UNKNOWN, MN_LBU, MN_LHU, MN_UNKNOWN, MN_UNKNOWN
	};
	localparam mnem_t STORE_CODE [8] = '{
		MN_SB, MN_SH, MN_SW, MN_UNKNOWN, MN_UNKNOWN, MN_UNKNOWN, MN_UNKNOWN,
		MN_UNKNOWN
	};
	localparam mnem_t BRANCH_CODE [8] = '{
		MN_BEQ, MN_BNE, MN_UNKNOWN, MN_UNKNOWN, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU
	};

	// Input transaction: instruction word and its address.
	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] instr;
	} in_t;

	// Result transaction: decoded fields.
	typedef struct packed {
		mnem_t              mnemonic;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] immediate;
		logic [31:0]        target;
	} out_t;

endpackage

### hdl/rvd_decode.sv
// Combinational decode of one instruction word into mnemonic, fields,
// immediate and branch or jump target.
// Depends on rvd_pkg for the transaction types, opcodes and code tables.
module rvd_decode (
	input  rvd_pkg::in_t  item,
	output rvd_pkg::out_t result
);

	logic [31:0] w;
	logic [6:0]  opc;
	logic [2:0]  fn3;
	logic        alt;
	logic [4:0]  rd;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [31:0] offset;
	logic [31:0] sum;
	rvd_pkg::mnem_t r_code;

	// Field extraction and the immediate formats.
	assign w     = item.instr;
	assign opc   = w[6:0];
	assign fn3   = w[14:12];
	assign alt   = w[25 + rvd_pkg::FN7_ALT_BIT];
	assign rd    = w[11:7];
	assign rs1   = w[19:15];
	assign rs2   = w[24:20];
	assign imm_i = {{20{w[31]}}, w[31:20]};
	assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
	assign imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
	assign imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
	assign imm_u = {12'd0, w[31:12]};

	// The target adder is shared by jal and the branches.
	assign offset = (opc == rvd_pkg::OPC_JAL) ? imm_j : imm_b;
	assign sum    = item.pc + offset;

	// Register-register operation by funct3 and the alternate funct7 bit.
	always_comb begin
		case (fn3)
			rvd_pkg::F3_ADD_SUB: r_code = alt ? rvd_pkg::MN_SUB : rvd_pkg::MN_ADD;
			rvd_pkg::F3_SLL:     r_code = rvd_pkg::MN_SLL;
			rvd_pkg::F3_SLT:     r_code = rvd_pkg::MN_SLT;
			rvd_pkg::F3_SLTU:    r_code = rvd_pkg::MN_SLTU;
			rvd_pkg::F3_XOR:     r_code = rvd_pkg::MN_XOR;
			rvd_pkg::F3_SRL_SRA: r_code = alt ? rvd_pkg::MN_SRA : rvd_pkg::MN_SRL;
			rvd_pkg::F3_OR:      r_code = rvd_pkg::MN_OR;
			rvd_pkg::F3_AND:     r_code = rvd_pkg::MN_AND;
			default:             r_code = rvd_pkg::MN_AND;
		endcase
	end

	// Per-opcode selection; anything not recognized gives MN_UNKNOWN and leaves all other fields zero.
	always_comb begin
		result.mnemonic  = rvd_pkg::MN_UNKNOWN;
		result.dest_reg  = 5'd0;
		result.src1_reg  = 5'd0;
		result.src2_reg  = 5'd0;
		result.immediate = 32'sd0;
		result.target    = 32'd0;
		case (opc)
			rvd_pkg::OPC_OP: begin
				result.mnemonic = r_code;
				result.dest_reg = rd;
				result.src1_reg = rs1;
				result.src2_reg = rs2;
			end
			rvd_pkg::OPC_OPIMM: begin
				if (fn3 == rvd_pkg::F3_ADDI) begin
					result.mnemonic  = rvd_pkg::MN_ADDI;
					result.dest_reg  = rd;
					result.src1_reg  = rs1;
					result.immediate = imm_i;
				end
			end
			rvd_pkg::OPC_LOAD: begin
				if (rvd_pkg::LOAD_CODE[fn3] != rvd_pkg::MN_UNKNOWN) begin
					result.mnemonic  = rvd_pkg::LOAD_CODE[fn3];
					result.dest_reg  = rd;
					result.src1_reg  = rs1;
					result.immediate = imm_i;
				end
			end
			rvd_pkg::OPC_STORE: begin
				if (rvd_pkg::STORE_CODE[fn3] != rvd_pkg::MN_UNKNOWN) begin
					result.mnemonic  = rvd_pkg::STORE_CODE[fn3];
					result.src1_reg  = rs1;
					result.src2_reg  = rs2;
					result.immediate = imm_s;
				end
			end
			rvd_pkg::OPC_AUIPC: begin
				result.mnemonic  = rvd_pkg::MN_AUIPC;
				result.dest_reg  = rd;
				result.immediate = imm_u;
			end
			rvd_pkg::OPC_LUI: begin
				result.mnemonic  = rvd_pkg::MN_LUI;
				result.dest_reg  = rd;
				result.immediate = imm_u;
			end
			rvd_pkg::OPC_JAL: begin
				result.mnemonic  = rvd_pkg::MN_JAL;
				result.dest_reg  = rd;
				result.immediate = imm_j;
				result.target    = sum;
			end
			rvd_pkg::OPC_BRANCH: begin
				if (rvd_pkg::BRANCH_CODE[fn3] != rvd_pkg::MN_UNKNOWN) begin
					result.mnemonic  = rvd_pkg::BRANCH_CODE[fn3];
					result.src1_reg  = rs1;
					result.src2_reg  = rs2;
					result.immediate = imm_b;
					result.target    = sum;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/rv32i_subset_instruction_decoder.sv
// Top level of the RV32I subset instruction decoder: input register, decode
// logic and result register with valid/stall flow control.
// Depends on rvd_pkg and rvd_decode.

// Decodes one instruction transaction per clock cycle while dec_stall is low. A
// transaction taken on inst is held in an input register, decoded by a single pass
// of logic and shown on dec from the result register. Each register advances
// whenever it is empty or the stage after it is moving, so the decoder sustains
// one transaction per cycle while dec_stall is low; the 32-bit target adder for
// jal and branches is the longest path between them.
// inst_stall rises only when both registers are full and dec_stall is high.
module rv32i_subset_instruction_decoder (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          inst_valid,
	output logic          inst_stall,
	input  rvd_pkg::in_t  inst,
	output logic          dec_valid,
	input  logic          dec_stall,
	output rvd_pkg::out_t dec
);

	logic          valid_s1;
	rvd_pkg::in_t  item_s1;
	logic          valid_s2;
	rvd_pkg::out_t result_s2;
	rvd_pkg::out_t decoded;
	logic          adv_s1;
	logic          adv_s2;

	// Each stage moves when it is empty or the stage after it moves.
	assign adv_s2     = !valid_s2 || !dec_stall;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign inst_stall = !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= inst_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && inst_valid) begin
			item_s1 <= inst;
		end
	end

	// Decode logic.
	rvd_decode u_decode (
		.item   (item_s1),
		.result (decoded)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign dec_valid = valid_s2;
	assign dec       = result_s2;

endmodule
